### design/ssa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_pkg
// Shared types and constants of the separation steering accumulator.
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int POS_W       = 32;
    localparam int DIFF_W      = 33;
    localparam int MAG_W       = 32;
    localparam int LIM_W       = 31;
    localparam int S_W         = 66;
    localparam int ROOT_W      = 33;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 1;

    // Iteration counts of the back-end units
    localparam int SQ_STEPS    = 4;
    localparam int SQRT_STEPS  = 33;
    localparam int QDIV_STEPS  = 31;
    localparam int PROD_STEPS  = 4;
    localparam int CDIV_STEPS  = 31;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACC = 1'b1;

    // Classified item: begin flag, or neighbour offset agent - neighbour
    typedef struct packed {
        logic                          is_begin;
        logic [2:0][DIFF_W-1:0]        diff;
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } job_slot_t;

endpackage

`default_nettype wire

### design/ssa_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_ifs
// Valid/ready channels: input items, results and configuration writes.
// ----------------------------------------------------------------------------
interface ssa_item_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (output valid, command, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, command, pos_x, pos_y, pos_z, output ready);
endinterface

interface ssa_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic               zero_distance;
    logic               saturated;

    modport source (output valid, accel_x, accel_y, accel_z, zero_distance, saturated,
                    input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, zero_distance, saturated,
                    output ready);
endinterface

interface ssa_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ssa_pkg::CFG_IDX_W-1:0]      index;
    logic [31:0]                        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### design/ssa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_front
// Accepts items, keeps the agent position and forms neighbour offsets.
// ----------------------------------------------------------------------------
module ssa_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    ssa_item_if.sink                 items,
    input  wire logic                q_full,
    output ssa_pkg::job_slot_t       push
);

    logic signed [ssa_pkg::POS_W-1:0] agent_reg [3];
    logic signed [ssa_pkg::POS_W-1:0] pos      [3];
    logic                             accept;

    assign pos[0] = items.pos_x;
    assign pos[1] = items.pos_y;
    assign pos[2] = items.pos_z;

    assign items.ready = !q_full;
    assign accept      = items.valid && !q_full;

    // Classify and form the offset with the current agent position
    always_comb
    begin
        push.valid        = accept;
        push.job.is_begin = !items.command;
        for (int i = 0; i < 3; i++)
        begin
            push.job.diff[i] = {agent_reg[i][31], agent_reg[i]} - {pos[i][31], pos[i]};
        end
    end

    // Agent position, loaded by a begin transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                agent_reg[i] <= '0;
            end
        end
        else if (accept && !items.command)
        begin
            for (int i = 0; i < 3; i++)
            begin
                agent_reg[i] <= pos[i];
            end
        end
    end

endmodule

`default_nettype wire

### design/ssa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module ssa_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ssa_pkg::job_slot_t  push,
    output logic                     full,
    output ssa_pkg::job_slot_t       head,
    input  wire logic                pop
);

    localparam int DEPTH = ssa_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ssa_pkg::job_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.job   = entry_reg[rd_ptr_reg];
    assign do_push    = push.valid && !full;
    assign do_pop     = pop && head.valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

`default_nettype wire

### design/ssa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ssa_back
// Sequencer: squared length, square root, strength division, component
// division and saturating accumulation, with a registered result.
// ----------------------------------------------------------------------------
module ssa_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ssa_pkg::job_slot_t           head,
    output logic                              pop,
    input  wire logic [31:0]                  decay,
    input  wire logic [ssa_pkg::LIM_W-1:0]    max_acc,
    ssa_result_if.source                      results
);

    localparam int NUM_W   = 32 + 2 * FRAC_BITS;
    localparam int NUMHI_W = NUM_W - ssa_pkg::QDIV_STEPS;
    localparam int S_W     = ssa_pkg::S_W;
    localparam int LIM_W   = ssa_pkg::LIM_W;
    localparam int ROOT_W  = ssa_pkg::ROOT_W;
    localparam int MAG_W   = ssa_pkg::MAG_W;
    localparam int SQR_W   = 36;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_SQRT = 3'd2;
    localparam logic [2:0] ST_QDIV = 3'd3;
    localparam logic [2:0] ST_PROD = 3'd4;
    localparam logic [2:0] ST_CDIV = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    logic [2:0]               state_reg;
    logic [2:0]               state_next;
    logic [5:0]               cnt_reg;
    logic [5:0]               cnt_next;

    logic                     begin_reg;
    logic                     zero_reg;
    logic                     neg_reg   [3];
    logic [MAG_W-1:0]         mag_reg   [3];
    logic [S_W-1:0]           s_reg;
    logic [63:0]              prod_reg;
    logic [S_W-1:0]           sq_src_reg;
    logic [SQR_W-1:0]         sq_rem_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic                     ovf_reg;
    logic [S_W-1:0]           qrem_reg;
    logic [LIM_W-1:0]         qlo_reg;
    logic [LIM_W-1:0]         strength_reg;
    logic [ROOT_W-1:0]        lane_rem_reg [3];
    logic [LIM_W-1:0]         lane_lo_reg  [3];
    logic signed [31:0]       acc_reg   [3];
    logic                     out_valid_reg;
    logic                     out_zero_reg;
    logic                     out_sat_reg;

    logic [MAG_W-1:0]         mag_sel;
    logic [MAG_W-1:0]         mul_b;
    logic [63:0]              mul_p;
    logic [S_W-1:0]           s_sum;
    logic [NUM_W-1:0]         num;
    logic [NUMHI_W-1:0]       num_hi;
    logic [SQR_W-1:0]         sq_sh;
    logic [SQR_W-1:0]         sq_trial;
    logic                     sq_ge;
    logic [S_W:0]             q_sh;
    logic                     q_ge;
    logic [S_W:0]             q_diff;
    logic [LIM_W-1:0]         q_final;
    logic [ROOT_W:0]          lane_sh   [3];
    logic                     lane_ge   [3];
    logic [ROOT_W:0]          lane_diff [3];
    logic [32:0]              add_val   [3];
    logic [32:0]              sum_ext   [3];
    logic                     sat_any;
    logic                     load_out;

    assign pop      = (state_reg == ST_IDLE) && head.valid;
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || results.ready);

    // Shared 32x32 multiplier
    assign mag_sel = (cnt_reg < 6'(3)) ? mag_reg[cnt_reg[1:0]] : '0;
    assign mul_b   = (state_reg == ST_SQ) ? mag_sel : {1'b0, strength_reg};
    assign mul_p   = mag_sel * mul_b;
    assign s_sum   = s_reg + {2'b00, prod_reg};

    // Strength numerator decay * 2^(2F); top part for the overflow test
    assign num    = {decay, {(2 * FRAC_BITS){1'b0}}};
    assign num_hi = num[NUM_W-1:ssa_pkg::QDIV_STEPS];

    // Square root step, two radicand bits a cycle
    assign sq_sh    = {sq_rem_reg[SQR_W-3:0], sq_src_reg[S_W-1:S_W-2]};
    assign sq_trial = SQR_W'({root_reg, 2'b01});
    assign sq_ge    = (sq_sh >= sq_trial);

    // Strength division step
    assign q_sh    = {qrem_reg, qlo_reg[LIM_W-1]};
    assign q_ge    = (q_sh >= {1'b0, s_reg});
    assign q_diff  = q_sh - {1'b0, s_reg};
    assign q_final = {qlo_reg[LIM_W-2:0], q_ge};

    // Component division lanes and saturating sums
    always_comb
    begin
        sat_any = 1'b0;
        for (int l = 0; l < 3; l++)
        begin
            lane_sh[l]   = {lane_rem_reg[l], lane_lo_reg[l][LIM_W-1]};
            lane_ge[l]   = (lane_sh[l] >= {1'b0, root_reg});
            lane_diff[l] = lane_sh[l] - {1'b0, root_reg};
            add_val[l]   = neg_reg[l] ? (~{2'b00, lane_lo_reg[l]} + 33'd1)
                                      : {2'b00, lane_lo_reg[l]};
            sum_ext[l]   = {acc_reg[l][31], acc_reg[l]} + add_val[l];
            if (sum_ext[l][32] != sum_ext[l][31])
            begin
                sat_any = 1'b1;
            end
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (head.valid)
                begin
                    state_next = head.job.is_begin ? ST_DONE : ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (cnt_reg == 6'(ssa_pkg::SQ_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = (s_sum == '0) ? ST_DONE : ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (cnt_reg == 6'(ssa_pkg::SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ovf_reg ? ST_PROD : ST_QDIV;
                end
            end
            ST_QDIV:
            begin
                if (cnt_reg == 6'(ssa_pkg::QDIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                if (cnt_reg == 6'(ssa_pkg::PROD_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_CDIV;
                end
            end
            ST_CDIV:
            begin
                if (cnt_reg == 6'(ssa_pkg::CDIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cnt_next = '0;
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                cnt_next   = '0;
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, sum and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_zero_reg  <= 1'b0;
            out_sat_reg   <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                out_zero_reg  <= zero_reg && !begin_reg;
                out_sat_reg   <= sat_any && !begin_reg && !zero_reg;
                for (int i = 0; i < 3; i++)
                begin
                    if (begin_reg)
                    begin
                        acc_reg[i] <= '0;
                    end
                    else if (!zero_reg)
                    begin
                        if (sum_ext[i][32:31] == 2'b01)
                        begin
                            acc_reg[i] <= 32'sh7FFF_FFFF;
                        end
                        else if (sum_ext[i][32:31] == 2'b10)
                        begin
                            acc_reg[i] <= 32'sh8000_0000;
                        end
                        else
                        begin
                            acc_reg[i] <= sum_ext[i][31:0];
                        end
                    end
                end
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                begin_reg <= head.job.is_begin;
                zero_reg  <= 1'b0;
                s_reg     <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    neg_reg[i] <= head.job.diff[i][ssa_pkg::DIFF_W-1];
                    mag_reg[i] <= head.job.diff[i][ssa_pkg::DIFF_W-1]
                                  ? MAG_W'(~head.job.diff[i] + 1'b1)
                                  : head.job.diff[i][MAG_W-1:0];
                end
            end
            ST_SQ:
            begin
                prod_reg <= mul_p;
                if (cnt_reg != '0)
                begin
                    s_reg <= s_sum;
                end
                if (cnt_reg == 6'(ssa_pkg::SQ_STEPS - 1))
                begin
                    zero_reg   <= (s_sum == '0);
                    sq_src_reg <= s_sum;
                    sq_rem_reg <= '0;
                    root_reg   <= '0;
                end
            end
            ST_SQRT:
            begin
                sq_src_reg <= {sq_src_reg[S_W-3:0], 2'b00};
                sq_rem_reg <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
                root_reg   <= {root_reg[ROOT_W-2:0], sq_ge};
                if (cnt_reg == '0)
                begin
                    ovf_reg  <= (S_W'(num_hi) >= s_reg);
                    qrem_reg <= S_W'(num_hi);
                    qlo_reg  <= num[LIM_W-1:0];
                end
                if (cnt_reg == 6'(ssa_pkg::SQRT_STEPS - 1))
                begin
                    strength_reg <= max_acc;
                end
            end
            ST_QDIV:
            begin
                qrem_reg <= q_ge ? q_diff[S_W-1:0] : q_sh[S_W-1:0];
                qlo_reg  <= q_final;
                if (cnt_reg == 6'(ssa_pkg::QDIV_STEPS - 1))
                begin
                    strength_reg <= (q_final > max_acc) ? max_acc : q_final;
                end
            end
            ST_PROD:
            begin
                prod_reg <= mul_p;
                for (int l = 0; l < 3; l++)
                begin
                    if (cnt_reg == 6'(l + 1))
                    begin
                        lane_rem_reg[l] <= ROOT_W'(prod_reg[62:LIM_W]);
                        lane_lo_reg[l]  <= prod_reg[LIM_W-1:0];
                    end
                end
            end
            ST_CDIV:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    lane_rem_reg[l] <= lane_ge[l] ? lane_diff[l][ROOT_W-1:0]
                                                  : lane_sh[l][ROOT_W-1:0];
                    lane_lo_reg[l]  <= {lane_lo_reg[l][LIM_W-2:0], lane_ge[l]};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign results.valid         = out_valid_reg;
    assign results.accel_x       = acc_reg[0];
    assign results.accel_y       = acc_reg[1];
    assign results.accel_z       = acc_reg[2];
    assign results.zero_distance = out_zero_reg;
    assign results.saturated     = out_sat_reg;

    // A skipped neighbour never reports saturation
    a_zero_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_zero_reg |-> !out_sat_reg)
        else $error("zero_distance and saturated both set");

    // Clamped strength is within the configured limit
    a_strength_lim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CDIV) |-> (strength_reg <= max_acc))
        else $error("strength above max_acceleration");

    // Component division remainder stays below the root in every lane
    a_lane_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CDIV) |-> (lane_rem_reg[0] < root_reg)
                                   && (lane_rem_reg[1] < root_reg)
                                   && (lane_rem_reg[2] < root_reg))
        else $error("component division remainder out of range");

endmodule

`default_nettype wire

### design/separation_steering_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none
// A begin item goes straight to the result register; a neighbour item
// passes through squares, square root, strength division (skipped when
// clamped early), products, component division and accumulation.
// The sequential back end takes one item at a time; the queue buffers others.
// Reset: rst_n clears agent position, sum, queue and result; both config
// registers reset to 1.0.
// ----------------------------------------------------------------------------
// separation_steering_accumulator
// Top level: configuration registers, front end, queue and back end.
// ----------------------------------------------------------------------------
module separation_steering_accumulator #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    ssa_cfg_if.sink       cfg,
    ssa_item_if.sink      items,
    ssa_result_if.source  results
);

    logic [31:0]                  decay_reg;
    logic [ssa_pkg::LIM_W-1:0]    max_acc_reg;
    ssa_pkg::job_slot_t           push;
    ssa_pkg::job_slot_t           head;
    logic                         q_full;
    logic                         pop;

    assign cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg   <= 32'(1) << FRAC_BITS;
            max_acc_reg <= ssa_pkg::LIM_W'(1) << FRAC_BITS;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                ssa_pkg::CFG_DECAY:   decay_reg   <= cfg.data;
                ssa_pkg::CFG_MAX_ACC: max_acc_reg <= cfg.data[ssa_pkg::LIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ssa_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .items  (items),
        .q_full (q_full),
        .push   (push)
    );

    ssa_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    ssa_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .pop     (pop),
        .decay   (decay_reg),
        .max_acc (max_acc_reg),
        .results (results)
    );

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the separation steering accumulator: directed
// corner items, then bursty random agent/neighbour sequences over several
// register settings, all checked by an inline predictor or by typed rows.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic CMD_BEGIN     = 1'b0;
    localparam logic CMD_NEIGHBOUR = 1'b1;
    localparam int   SETTLE        = 150;
    localparam int   CYCLE_LIMIT   = 2000000;
    localparam int   RANDOM_ITEMS  = 80;
    localparam logic signed [31:0] PMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] PMIN = 32'sh80000000;

    typedef struct {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic               zd;
        logic               sat;
    } sum_t;

    typedef struct {
        logic               cmd;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               typed;
        sum_t               want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ssa_cfg_if    cfg ();
    ssa_item_if   items ();
    ssa_result_if results ();

    separation_steering_accumulator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .items   (items),
        .results (results)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state
    logic signed [31:0] agent_pos [3];
    logic signed [31:0] accel_sum [3];
    logic [31:0]        decay_reg;
    logic [30:0]        max_acc_reg;
    sum_t               pending_sums [$];

    int errors = 0;
    int cycles = 0;
    int n_items = 0;
    int n_results = 0;
    int n_zero = 0;
    int n_sat = 0;
    int burst_left = 0;
    logic [7:0] stall_pat = 8'hFF;

    // Work out the running sum for one accepted item
    function automatic sum_t next_sum(logic cmd, logic signed [31:0] x,
                                      logic signed [31:0] y, logic signed [31:0] z);
        sum_t r;
        logic signed [31:0] p [3];
        longint d [3];
        logic [63:0] mag [3];
        logic [127:0] sq, root, trial, quot;
        logic [63:0] strength, comp;
        longint v;
        p[0] = x; p[1] = y; p[2] = z;
        r.zd = 1'b0;
        r.sat = 1'b0;
        if (cmd == CMD_BEGIN)
        begin
            for (int i = 0; i < 3; i++)
            begin
                agent_pos[i] = p[i];
                accel_sum[i] = '0;
            end
        end
        else
        begin
            sq = '0;
            for (int i = 0; i < 3; i++)
            begin
                d[i] = longint'(agent_pos[i]) - longint'(p[i]);
                mag[i] = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
                sq += 128'(mag[i]) * 128'(mag[i]);
            end
            if (sq == '0)
                r.zd = 1'b1;
            else
            begin
                // floor square root, one bit at a time
                root = '0;
                for (int b = 34; b >= 0; b--)
                begin
                    trial = root | (128'd1 << b);
                    if (trial * trial <= sq)
                        root = trial;
                end
                quot = (128'(decay_reg) << 32) / sq;
                strength = (quot > 128'(max_acc_reg)) ? 64'(max_acc_reg) : quot[63:0];
                for (int i = 0; i < 3; i++)
                begin
                    comp = (mag[i] * strength) / root[63:0];
                    v = longint'(accel_sum[i]) + ((d[i] < 0) ? -longint'(comp)
                                                             : longint'(comp));
                    if (v > longint'(PMAX))
                    begin
                        v = PMAX;
                        r.sat = 1'b1;
                    end
                    else if (v < longint'(PMIN))
                    begin
                        v = PMIN;
                        r.sat = 1'b1;
                    end
                    accel_sum[i] = v[31:0];
                end
            end
        end
        r.ax = accel_sum[0];
        r.ay = accel_sum[1];
        r.az = accel_sum[2];
        return r;
    endfunction

    // Timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d sums outstanding", $time, pending_sums.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver stall pattern, refreshed now and then
    always @(negedge clk)
    begin
        if (cycles % 64 == 0)
            stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
        results.ready <= stall_pat[cycles % 8] | (stall_pat == 8'h00);
    end

    // Result checking
    always @(posedge clk)
    begin
        sum_t w;
        if (rst_n && results.valid && results.ready)
        begin
            n_results++;
            if (results.zero_distance)
                n_zero++;
            if (results.saturated)
                n_sat++;
            if (pending_sums.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, actual %h %h %h zd=%b sat=%b",
                         $time, results.accel_x, results.accel_y, results.accel_z,
                         results.zero_distance, results.saturated);
            end
            else
            begin
                w = pending_sums.pop_front();
                if (results.accel_x !== w.ax || results.accel_y !== w.ay ||
                    results.accel_z !== w.az || results.zero_distance !== w.zd ||
                    results.saturated !== w.sat)
                begin
                    errors++;
                    $display("%0t mismatch: expected %h %h %h zd=%b sat=%b", $time,
                             w.ax, w.ay, w.az, w.zd, w.sat);
                    $display("%0t            actual %h %h %h zd=%b sat=%b", $time,
                             results.accel_x, results.accel_y, results.accel_z,
                             results.zero_distance, results.saturated);
                end
            end
        end
    end

    // Send one item, bursts separated by random gaps
    task automatic send_item(logic cmd, logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z, logic typed, sum_t want);
        sum_t got;
        if (burst_left == 0)
        begin
            items.valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        burst_left--;
        items.valid = 1'b1;
        items.command = cmd;
        items.pos_x = x;
        items.pos_y = y;
        items.pos_z = z;
        do
            @(posedge clk);
        while (!items.ready);
        got = next_sum(cmd, x, y, z);
        pending_sums.push_back(typed ? want : got);
        n_items++;
        @(negedge clk);
        if (burst_left == 0)
            items.valid = 1'b0;
    endtask

    task automatic write_reg(logic [ssa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data = val;
        do
            @(posedge clk);
        while (!cfg.ready);
        if (idx == ssa_pkg::CFG_DECAY)
            decay_reg = val;
        else
            max_acc_reg = val[30:0];
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic drain;
        items.valid = 1'b0;
        burst_left = 0;
        while (pending_sums.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Random item: new agent, or neighbour near, on or far from the agent
    task automatic random_item;
        logic signed [31:0] p [3];
        logic [31:0] off;
        int mode;
        mode = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++)
        begin
            off = $urandom & ((32'd1 << $urandom_range(0, 31)) - 1);
            p[i] = $urandom_range(0, 1) ? agent_pos[i] + off : agent_pos[i] - off;
        end
        if (mode < 12)
            send_item(CMD_BEGIN, $urandom, $urandom, $urandom, 1'b0, '{default: '0});
        else if (mode < 20)
            send_item(CMD_NEIGHBOUR, agent_pos[0], agent_pos[1], agent_pos[2], 1'b0,
                      '{default: '0});
        else if (mode < 35)
            send_item(CMD_NEIGHBOUR, $urandom, $urandom, $urandom, 1'b0, '{default: '0});
        else
            send_item(CMD_NEIGHBOUR, p[0], p[1], p[2], 1'b0, '{default: '0});
    endtask

    row_t dir_rows [] = '{
        '{CMD_NEIGHBOUR, 0, 0, 0, 1'b1, '{0, 0, 0, 1'b1, 1'b0}},
        '{CMD_BEGIN, PMAX, PMIN, 0, 1'b1, '{0, 0, 0, 1'b0, 1'b0}},
        '{CMD_NEIGHBOUR, PMIN, PMAX, PMAX, 1'b0, '{default: '0}},
        '{CMD_NEIGHBOUR, PMAX, PMIN, 0, 1'b0, '{default: '0}},
        '{CMD_BEGIN, 0, 0, 0, 1'b1, '{0, 0, 0, 1'b0, 1'b0}},
        '{CMD_NEIGHBOUR, 32'sh10000, 0, 0, 1'b1, '{-32'sh10000, 0, 0, 1'b0, 1'b0}},
        '{CMD_NEIGHBOUR, 0, -32'sh10000, 0, 1'b1,
          '{-32'sh10000, 32'sh10000, 0, 1'b0, 1'b0}},
        '{CMD_NEIGHBOUR, 0, 0, 1, 1'b0, '{default: '0}},
        '{CMD_NEIGHBOUR, -1, -1, -1, 1'b0, '{default: '0}},
        '{CMD_NEIGHBOUR, PMIN, PMIN, PMIN, 1'b0, '{default: '0}},
        '{CMD_BEGIN, -1, 12345, PMIN, 1'b1, '{0, 0, 0, 1'b0, 1'b0}},
        '{CMD_NEIGHBOUR, 32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F, 1'b0,
          '{default: '0}},
        '{CMD_NEIGHBOUR, -1, 12345, PMIN, 1'b0, '{default: '0}},
        '{CMD_NEIGHBOUR, 32'sh00000100, 32'sh00000100, PMIN, 1'b0, '{default: '0}}
    };

    // Register settings per phase: decay, clamp
    logic [31:0] phase_decay [5] = '{32'h00010000, 32'hFFFFFFFF, 32'h00000000,
                                     32'h12345678, 32'h00400000};
    logic [31:0] phase_max [5]   = '{32'h00010000, 32'h7FFFFFFF, 32'h00010000,
                                     32'h00000000, 32'h00200000};

    initial
    begin
        items.valid = 1'b0;
        items.command = CMD_BEGIN;
        items.pos_x = '0;
        items.pos_y = '0;
        items.pos_z = '0;
        cfg.valid = 1'b0;
        cfg.index = ssa_pkg::CFG_DECAY;
        cfg.data = '0;
        results.ready = 1'b0;
        decay_reg = 32'h00010000;
        max_acc_reg = 31'h00010000;
        for (int i = 0; i < 3; i++)
        begin
            agent_pos[i] = '0;
            accel_sum[i] = '0;
        end
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Corner items at reset settings
        foreach (dir_rows[k])
            send_item(dir_rows[k].cmd, dir_rows[k].x, dir_rows[k].y, dir_rows[k].z,
                      dir_rows[k].typed, dir_rows[k].want);

        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph != 0)
            begin
                drain();
                write_reg(ssa_pkg::CFG_DECAY, phase_decay[ph]);
                write_reg(ssa_pkg::CFG_MAX_ACC, phase_max[ph]);
            end
            // close neighbours pile up and hit the clamp at strong settings
            send_item(CMD_BEGIN, 0, 0, 0, 1'b0, '{default: '0});
            repeat (3) send_item(CMD_NEIGHBOUR, -1, 1, -1, 1'b0, '{default: '0});
            for (int n = 0; n < RANDOM_ITEMS; n++)
                random_item();
        end

        drain();
        $display("Covered %0d items and %0d results over 5 register settings.",
                 n_items, n_results);
        $display("Coincident neighbours: %0d, saturating items: %0d, mismatches: %0d.",
                 n_zero, n_sat, errors);
        if (errors == 0 && pending_sums.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

### sim.f
design/ssa_pkg.sv
design/ssa_ifs.sv
design/ssa_front.sv
design/ssa_queue.sv
design/ssa_back.sv
design/separation_steering_accumulator.sv
tb/sv/tb_top.sv
